/* hw/rtl/wgs_pkg.sv */
package wgs_pkg;

    // Defaults for the grid size; the top level takes them as parameters.
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    localparam int WORD_W      = 32;
    localparam int COEFF_W     = 15;
    localparam int OPC_W       = 2;
    localparam logic [COEFF_W-1:0] COEFF_RESET = 15'd6554;

    // Stencil arithmetic widths: the neighbour term, twice the centre minus the
    // previous value, the coupling product and the final sum before saturation.
    localparam int LAP_W  = 35;
    localparam int DCP_W  = 34;
    localparam int PROD_W = LAP_W + COEFF_W + 1;
    localparam int SUM_W  = 36;

    // Cycles from the last scan read to the last write-back of a step.
    localparam int DRAIN_CYCLES = 5;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    typedef enum logic [OPC_W-1:0] {
        OP_IMPULSE = 2'd0,
        OP_STEP    = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef struct packed {
        logic load;     // capture the operands of an accepted word
        logic clear;    // write zero to both fields at the scan address
        logic scan;     // stream the current field at the scan address
        logic cell_wr;  // write back the impulse sum
        logic capture;  // load the result registers
    } ctrl_cmd_t;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic in_range;
        in_range = (&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1]);
        if (in_range) begin
            sat_word = v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            sat_word = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            sat_word = {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

endpackage

/* hw/rtl/wgs_ram.sv */
module wgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read and a write to the same address return the old word.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

/* hw/rtl/wgs_ctrl.sv */
module wgs_ctrl
    import wgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    localparam int COL_W = $clog2(GRID_COLS),
    localparam int ROW_W = $clog2(GRID_ROWS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OPC_W-1:0] opcode,
    output logic             busy,
    output logic             result_strobe,
    output ctrl_cmd_t        cmd,
    output logic [ROW_W-1:0] scan_row,
    output logic [COL_W-1:0] scan_col
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_IMP_RD,
        ST_IMP_WR,
        ST_RD_RD,
        ST_RD_DONE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

    state_t             state_reg;
    logic               busy_reg;
    logic               strobe_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_reg;
    logic [DRAIN_W-1:0] drain_reg;
    logic               accept;
    logic               last_cell;

    assign accept    = start && !busy_reg;
    assign last_cell = (row_reg == LAST_ROW) && (col_reg == LAST_COL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            busy_reg   <= 1'b1;
            strobe_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            drain_reg  <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR, ST_SCAN:
                begin
                    if (last_cell)
                    begin
                        row_reg <= '0;
                        col_reg <= '0;
                        if (state_reg == ST_CLEAR)
                        begin
                            state_reg <= ST_IDLE;
                            busy_reg  <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_DRAIN;
                            drain_reg <= DRAIN_W'(DRAIN_CYCLES - 1);
                        end
                    end
                    else if (col_reg == LAST_COL)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode_t'(opcode))
                            OP_IMPULSE:
                            begin
                                state_reg <= ST_IMP_RD;
                                busy_reg  <= 1'b1;
                            end
                            OP_STEP:
                            begin
                                state_reg <= ST_SCAN;
                                busy_reg  <= 1'b1;
                            end
                            OP_READ:
                            begin
                                state_reg <= ST_RD_RD;
                                busy_reg  <= 1'b1;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_IMP_RD:
                begin
                    state_reg <= ST_IMP_WR;
                end
                ST_IMP_WR:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
                ST_RD_RD:
                begin
                    state_reg <= ST_RD_DONE;
                end
                ST_RD_DONE:
                begin
                    state_reg  <= ST_IDLE;
                    busy_reg   <= 1'b0;
                    strobe_reg <= 1'b1;
                end
                ST_DRAIN:
                begin
                    if (drain_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                    else
                    begin
                        drain_reg <= drain_reg - DRAIN_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy          = busy_reg;
    assign result_strobe = strobe_reg;
    assign scan_row      = row_reg;
    assign scan_col      = col_reg;

    assign cmd.load    = accept;
    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign cmd.scan    = (state_reg == ST_SCAN);
    assign cmd.cell_wr = (state_reg == ST_IMP_WR);
    assign cmd.capture = (state_reg == ST_RD_DONE);

    a_strobe_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_RD_DONE))
        else $error("result strobe without a completed read");

    a_busy_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != ST_IDLE))
        else $error("busy flag out of step with the controller state");

    a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= LAST_ROW) && (col_reg <= LAST_COL))
        else $error("scan address left the grid");

    a_scan_starts_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) != ST_SCAN) |-> (row_reg == '0 && col_reg == '0))
        else $error("step scan did not start at the first cell");

endmodule

/* hw/rtl/wgs_dpath.sv */
module wgs_dpath
    import wgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    localparam int COL_W = $clog2(GRID_COLS),
    localparam int ROW_W = $clog2(GRID_ROWS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    input  logic [ROW_W-1:0]         scan_row,
    input  logic [COL_W-1:0]         scan_col,
    input  logic [COL_W-1:0]         col_index,
    input  logic [ROW_W-1:0]         row_index,
    input  logic signed [WORD_W-1:0] impulse_value,
    input  logic                     cfg_we,
    input  logic [COEFF_W-1:0]       cfg_wdata,
    output logic signed [WORD_W-1:0] cell_value,
    output logic [COL_W-1:0]         cell_col,
    output logic [ROW_W-1:0]         cell_row
);

    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CELLS_PAD = 1 << ADDR_W;
    localparam int LINE_PAD  = 1 << COL_W;

    // Field memories are addressed by {row, column}; cells beyond the grid are never used.
    logic              cur_we;
    logic [ADDR_W-1:0] cur_waddr;
    logic [WORD_W-1:0] cur_wdata;
    logic [ADDR_W-1:0] cur_raddr;
    logic [WORD_W-1:0] cur_rdata;
    logic              prev_we;
    logic [ADDR_W-1:0] prev_waddr;
    logic [WORD_W-1:0] prev_wdata;
    logic [ADDR_W-1:0] prev_raddr;
    logic [WORD_W-1:0] prev_rdata;
    logic [WORD_W-1:0] lb1_rdata;
    logic [WORD_W-1:0] lb2_rdata;

    logic [COEFF_W-1:0]       coeff_reg;
    logic [COL_W-1:0]         op_col_reg;
    logic [ROW_W-1:0]         op_row_reg;
    logic signed [WORD_W-1:0] op_imp_reg;
    logic                     op_inside;
    logic [ADDR_W-1:0]        op_addr;

    logic                     s_valid_reg;
    logic [ROW_W-1:0]         s_row_reg;
    logic [COL_W-1:0]         s_col_reg;
    logic                     w_valid_reg;
    logic [ROW_W-1:0]         w_row_reg;
    logic [COL_W-1:0]         w_col_reg;

    // Window taps: middle line (east, centre, west), top line and bottom line.
    logic signed [WORD_W-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [WORD_W-1:0] t1_reg, t2_reg;
    logic signed [WORD_W-1:0] b1_reg, b2_reg;

    logic                     w_interior;
    logic [ADDR_W-1:0]        w_addr;
    logic signed [LAP_W-1:0]  lap;
    logic signed [DCP_W-1:0]  dcp;

    logic                     bs_valid_reg;
    logic signed [LAP_W-1:0]  bs_lap_reg;
    logic signed [DCP_W-1:0]  bs_dcp_reg;
    logic signed [WORD_W-1:0] bs_cur_reg;
    logic [ADDR_W-1:0]        bs_addr_reg;

    logic signed [PROD_W-1:0] prod;
    logic                     cs_valid_reg;
    logic signed [PROD_W-1:0] cs_prod_reg;
    logic signed [DCP_W-1:0]  cs_dcp_reg;
    logic signed [WORD_W-1:0] cs_cur_reg;
    logic [ADDR_W-1:0]        cs_addr_reg;

    logic [PROD_W-1:0]        prod_biased;
    logic signed [LAP_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  step_sum;
    logic                     ds_valid_reg;
    logic signed [WORD_W-1:0] ds_next_reg;
    logic signed [WORD_W-1:0] ds_cur_reg;
    logic [ADDR_W-1:0]        ds_addr_reg;

    logic signed [SUM_W-1:0]  imp_sum;

    logic signed [WORD_W-1:0] out_value_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic [ROW_W-1:0]         out_row_reg;

    assign op_addr   = {op_row_reg, op_col_reg};
    assign op_inside = ({1'b0, op_col_reg} < (COL_W + 1)'(GRID_COLS))
                    && ({1'b0, op_row_reg} < (ROW_W + 1)'(GRID_ROWS));

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg    <= COEFF_RESET;
            s_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            bs_valid_reg <= 1'b0;
            cs_valid_reg <= 1'b0;
            ds_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                coeff_reg <= cfg_wdata;
            end
            s_valid_reg  <= cmd.scan;
            w_valid_reg  <= s_valid_reg;
            bs_valid_reg <= w_interior;
            cs_valid_reg <= bs_valid_reg;
            ds_valid_reg <= cs_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_col_reg <= col_index;
            op_row_reg <= row_index;
            op_imp_reg <= impulse_value;
        end
        s_row_reg <= scan_row;
        s_col_reg <= scan_col;
        w_row_reg <= s_row_reg;
        w_col_reg <= s_col_reg;

        m1_reg <= $signed(lb1_rdata);
        m2_reg <= m1_reg;
        m3_reg <= m2_reg;
        t1_reg <= $signed(lb2_rdata);
        t2_reg <= t1_reg;
        b1_reg <= $signed(cur_rdata);
        b2_reg <= b1_reg;

        bs_lap_reg  <= lap;
        bs_dcp_reg  <= dcp;
        bs_cur_reg  <= m2_reg;
        bs_addr_reg <= w_addr;

        cs_prod_reg <= prod;
        cs_dcp_reg  <= bs_dcp_reg;
        cs_cur_reg  <= bs_cur_reg;
        cs_addr_reg <= bs_addr_reg;

        ds_next_reg <= sat_word(step_sum);
        ds_cur_reg  <= cs_cur_reg;
        ds_addr_reg <= cs_addr_reg;

        if (cmd.capture)
        begin
            out_value_reg <= op_inside ? $signed(cur_rdata) : '0;
            out_col_reg   <= op_col_reg;
            out_row_reg   <= op_row_reg;
        end
    end

    // The centre cell sits one row and one column behind the word just streamed in.
    assign w_interior = w_valid_reg && (w_row_reg >= ROW_W'(2)) && (w_col_reg >= COL_W'(2));
    assign w_addr     = {w_row_reg - ROW_W'(1), w_col_reg - COL_W'(1)};

    assign lap  = LAP_W'(t2_reg) + LAP_W'(b2_reg) + LAP_W'(m1_reg) + LAP_W'(m3_reg)
                - (LAP_W'(m2_reg) <<< 2);
    assign dcp  = (DCP_W'(m2_reg) <<< 1) - DCP_W'($signed(prev_rdata));

    assign prod = $signed({1'b0, coeff_reg}) * bs_lap_reg;

    // Round half up: add one half and take the floor of the shift.
    assign prod_biased = cs_prod_reg + PROD_W'(32768);
    assign rnd         = $signed(prod_biased[PROD_W-1:16]);
    assign step_sum    = SUM_W'(cs_dcp_reg) + SUM_W'(rnd);

    assign imp_sum = SUM_W'($signed(cur_rdata)) + SUM_W'(op_imp_reg);

    assign cur_raddr  = cmd.scan ? {scan_row, scan_col} : op_addr;
    assign prev_raddr = {s_row_reg - ROW_W'(1), s_col_reg - COL_W'(1)};

    always_comb
    begin
        if (cmd.clear)
        begin
            cur_we    = 1'b1;
            cur_waddr = {scan_row, scan_col};
            cur_wdata = '0;
        end
        else if (cmd.cell_wr)
        begin
            cur_we    = op_inside;
            cur_waddr = op_addr;
            cur_wdata = sat_word(imp_sum);
        end
        else
        begin
            cur_we    = ds_valid_reg;
            cur_waddr = ds_addr_reg;
            cur_wdata = ds_next_reg;
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            prev_we    = 1'b1;
            prev_waddr = {scan_row, scan_col};
            prev_wdata = '0;
        end
        else
        begin
            prev_we    = ds_valid_reg;
            prev_waddr = ds_addr_reg;
            prev_wdata = ds_cur_reg;
        end
    end

    wgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS_PAD)) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    wgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS_PAD)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    // Two line buffers hold the previous one and two rows of the stream.
    wgs_ram #(.WIDTH(WORD_W), .DEPTH(LINE_PAD)) u_line1_ram (
        .clk   (clk),
        .we    (s_valid_reg),
        .waddr (s_col_reg),
        .wdata (cur_rdata),
        .raddr (scan_col),
        .rdata (lb1_rdata)
    );

    wgs_ram #(.WIDTH(WORD_W), .DEPTH(LINE_PAD)) u_line2_ram (
        .clk   (clk),
        .we    (s_valid_reg),
        .waddr (s_col_reg),
        .wdata (lb1_rdata),
        .raddr (scan_col),
        .rdata (lb2_rdata)
    );

    assign cell_value = out_value_reg;
    assign cell_col   = out_col_reg;
    assign cell_row   = out_row_reg;

endmodule

/* hw/rtl/wave_grid_stencil_step_unit.sv */
// Channel   Handshake                    Payload
// input     start, accepted when !busy   opcode, col_index, row_index, impulse_value
// result    result_strobe, one cycle     cell_value, cell_col, cell_row
// config    cfg_we                       cfg_wdata (coupling coefficient)
//
// After reset busy stays high while both fields are cleared.
// An impulse or a read word holds busy while it runs; a read's result comes as busy falls.
// A step holds busy while the current field memory delivers one cell per cycle and then
// while the stencil pipeline drains its tail.
// The receiver cannot stall; each result word is shown for exactly one cycle.
module wave_grid_stencil_step_unit
    import wgs_pkg::*;
#(
    parameter int GRID_COLS = GRID_COLS_DEF,
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    localparam int COL_W = $clog2(GRID_COLS),
    localparam int ROW_W = $clog2(GRID_ROWS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OPC_W-1:0]         opcode,
    input  logic [COL_W-1:0]         col_index,
    input  logic [ROW_W-1:0]         row_index,
    input  logic signed [WORD_W-1:0] impulse_value,
    input  logic                     cfg_we,
    input  logic [COEFF_W-1:0]       cfg_wdata,
    output logic                     result_strobe,
    output logic signed [WORD_W-1:0] cell_value,
    output logic [COL_W-1:0]         cell_col,
    output logic [ROW_W-1:0]         cell_row
);

    ctrl_cmd_t        cmd;
    logic [ROW_W-1:0] scan_row;
    logic [COL_W-1:0] scan_col;

    wgs_ctrl #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .busy          (busy),
        .result_strobe (result_strobe),
        .cmd           (cmd),
        .scan_row      (scan_row),
        .scan_col      (scan_col)
    );

    wgs_dpath #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .scan_row      (scan_row),
        .scan_col      (scan_col),
        .col_index     (col_index),
        .row_index     (row_index),
        .impulse_value (impulse_value),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cell_value    (cell_value),
        .cell_col      (cell_col),
        .cell_row      (cell_row)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import wgs_pkg::*;

    localparam int COLS = GRID_COLS_DEF;
    localparam int ROWS = GRID_ROWS_DEF;
    localparam int CELLS = COLS * ROWS;
    localparam int COL_W = $clog2(COLS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int QUIET_LIMIT = 20000;
    localparam int DIR_N = 25;
    localparam int PHASES = 4;
    localparam int WORDS_PER_PHASE = 29;
    localparam longint HEIGHT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint HEIGHT_MIN = -HEIGHT_MAX - 1;

    typedef struct {
        logic signed [WORD_W-1:0] value;
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         row;
    } readback_t;

    typedef struct {
        opcode_t           op;
        int                col;
        int                row;
        logic [WORD_W-1:0] amount;
        bit                pinned;
        logic [WORD_W-1:0] pinned_value;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OPC_W-1:0]         opcode = OP_NOP;
    logic [COL_W-1:0]         col_index = '0;
    logic [ROW_W-1:0]         row_index = '0;
    logic signed [WORD_W-1:0] impulse_value = '0;
    logic                     cfg_we = 1'b0;
    logic [COEFF_W-1:0]       cfg_wdata = '0;
    logic                     result_strobe;
    logic signed [WORD_W-1:0] cell_value;
    logic [COL_W-1:0]         cell_col;
    logic [ROW_W-1:0]         cell_row;

    // A read word from the directed table may carry a value typed in by hand.
    logic                     pinned = 1'b0;
    logic [WORD_W-1:0]        pinned_value = '0;

    wave_grid_stencil_step_unit #(
        .GRID_COLS(COLS),
        .GRID_ROWS(ROWS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .col_index(col_index),
        .row_index(row_index),
        .impulse_value(impulse_value),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .result_strobe(result_strobe),
        .cell_value(cell_value),
        .cell_col(cell_col),
        .cell_row(cell_row)
    );

    int cur_height [CELLS];
    int prev_height [CELLS];
    int next_height [CELLS];
    int coupling_k = int'(COEFF_RESET);

    readback_t readback_q [$];
    int n_errors = 0;
    int n_words = 0;
    int n_steps = 0;
    int n_reads = 0;
    int quiet = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int sat_height(input longint v);
        if (v > HEIGHT_MAX)
        begin
            return int'(HEIGHT_MAX);
        end
        if (v < HEIGHT_MIN)
        begin
            return int'(HEIGHT_MIN);
        end
        return int'(v);
    endfunction

    // All reads use the field as it stood before the step; border cells are left alone.
    task automatic apply_wave_step();
        longint k;
        longint centre;
        longint lap;
        longint coupled;
        int i;
        k = longint'(coupling_k);
        for (int r = 1; r < ROWS - 1; r++)
        begin
            for (int c = 1; c < COLS - 1; c++)
            begin
                i = r * COLS + c;
                centre = longint'(cur_height[i]);
                lap = longint'(cur_height[i-1]) + cur_height[i+1] + cur_height[i-COLS]
                    + cur_height[i+COLS] - 4 * centre;
                // Round half up: add half an LSB, then an arithmetic shift floors.
                coupled = (k * lap + 32768) >>> 16;
                next_height[i] = sat_height(2 * centre - prev_height[i] + coupled);
            end
        end
        for (int r = 1; r < ROWS - 1; r++)
        begin
            for (int c = 1; c < COLS - 1; c++)
            begin
                i = r * COLS + c;
                prev_height[i] = cur_height[i];
                cur_height[i] = next_height[i];
            end
        end
    endtask

    always @(posedge clk)
    begin
        readback_t want;
        readback_t due;
        int idx;
        logic took;
        if (result_strobe === 1'b1)
        begin
            if (readback_q.size() == 0)
            begin
                n_errors++;
                $display("%0t: result word with nothing expected: (%0d,%0d) value %h",
                         $time, cell_col, cell_row, cell_value);
            end
            else
            begin
                want = readback_q.pop_front();
                n_reads++;
                if (cell_value !== want.value)
                begin
                    n_errors++;
                    $display("%0t: cell_value of (%0d,%0d) expected %h got %h",
                             $time, want.col, want.row, want.value, cell_value);
                end
                if (cell_col !== want.col)
                begin
                    n_errors++;
                    $display("%0t: cell_col expected %0d got %0d", $time, want.col, cell_col);
                end
                if (cell_row !== want.row)
                begin
                    n_errors++;
                    $display("%0t: cell_row expected %0d got %0d", $time, want.row, cell_row);
                end
            end
        end
        if (rst_n && cfg_we === 1'b1)
        begin
            coupling_k = int'(cfg_wdata);
        end
        took = rst_n && start && (busy === 1'b0);
        if (took)
        begin
            idx = int'(row_index) * COLS + int'(col_index);
            n_words++;
            case (opcode)
                OP_IMPULSE:
                begin
                    cur_height[idx] = sat_height(longint'(cur_height[idx])
                                                 + longint'(impulse_value));
                end
                OP_STEP:
                begin
                    apply_wave_step();
                    n_steps++;
                end
                OP_READ:
                begin
                    due.value = pinned ? $signed(pinned_value) : cur_height[idx];
                    due.col   = col_index;
                    due.row   = row_index;
                    readback_q.insert(readback_q.size(), due);
                end
                default:
                begin
                end
            endcase
        end
        quiet = (took || result_strobe === 1'b1) ? 0 : quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, quiet);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(input opcode_t op, input int col, input int row,
                             input logic [WORD_W-1:0] amount, input bit pin,
                             input logic [WORD_W-1:0] pin_value, input int idle_pct);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        col_index <= col[COL_W-1:0];
        row_index <= row[ROW_W-1:0];
        impulse_value <= amount;
        pinned <= pin;
        pinned_value <= pin_value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Stop sending and wait until every read-back is in and the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (readback_q.size() != 0 || busy !== 1'b0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES + 4) @(posedge clk);
    endtask

    task automatic write_coupling(input logic [COEFF_W-1:0] k);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int near_focus(input int f, input int span);
        if ($urandom_range(99) < 70)
        begin
            return f + int'($urandom_range(8)) - 4;
        end
        return int'($urandom_range(span - 1));
    endfunction

    // Mostly impulses and reads around one spot, so that steps spread something worth reading.
    task automatic random_word(input int idle_pct, input int focus_c, input int focus_r);
        int sel;
        int mag;
        opcode_t op;
        logic [WORD_W-1:0] amount;
        sel = $urandom_range(99);
        mag = $urandom_range(99);
        if (mag < 40)
        begin
            amount = $urandom_range(32'h0004_0000);
            if ($urandom_range(1))
            begin
                amount = -amount;
            end
        end
        else if (mag < 70)
        begin
            amount = $urandom;
        end
        else if (mag < 85)
        begin
            amount = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        else
        begin
            amount = $signed($urandom) >>> 6;
        end
        if (sel < 30)
        begin
            op = OP_IMPULSE;
        end
        else if (sel < 42)
        begin
            op = OP_STEP;
        end
        else if (sel < 92)
        begin
            op = OP_READ;
        end
        else
        begin
            op = OP_NOP;
        end
        send_word(op, near_focus(focus_c, COLS), near_focus(focus_r, ROWS), amount,
                  1'b0, '0, idle_pct);
    endtask

    initial
    begin
        dir_row_t dir_rows [DIR_N];
        int phase_idle [PHASES];
        logic [COEFF_W-1:0] phase_k [PHASES];
        int focus_c;
        int focus_r;

        dir_rows = '{
            '{OP_READ,     0,  0, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{OP_READ,    63, 63, 32'h0000_0000, 1'b1, 32'h0000_0000},
            // Impulses that push one cell past the top of the range, then another past the bottom.
            '{OP_IMPULSE, 10, 10, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
            '{OP_IMPULSE, 10, 10, 32'h0000_0001, 1'b0, 32'h0000_0000},
            '{OP_READ,    10, 10, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
            '{OP_IMPULSE, 20, 20, 32'h8000_0000, 1'b0, 32'h0000_0000},
            '{OP_IMPULSE, 20, 20, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
            '{OP_READ,    20, 20, 32'h0000_0000, 1'b1, 32'h8000_0000},
            '{OP_IMPULSE,  0,  5, 32'h0001_0000, 1'b0, 32'h0000_0000},
            '{OP_IMPULSE, 63,  0, 32'hFFFF_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    63,  0, 32'h0000_0000, 1'b1, 32'hFFFF_0000},
            '{OP_NOP,     10, 10, 32'h1234_5678, 1'b0, 32'h0000_0000},
            '{OP_READ,    10, 10, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
            '{OP_IMPULSE, 40, 30, 32'h0002_8000, 1'b0, 32'h0000_0000},
            '{OP_STEP,     0,  0, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    10, 10, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    11, 10, 32'h0000_0000, 1'b0, 32'h0000_0000},
            // Border cells are never stepped, so this one keeps its impulse.
            '{OP_READ,     0,  5, 32'h0000_0000, 1'b1, 32'h0001_0000},
            '{OP_READ,     1,  5, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    21, 20, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    40, 30, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_STEP,     0,  0, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    40, 31, 32'h0000_0000, 1'b0, 32'h0000_0000},
            '{OP_READ,    63,  0, 32'h0000_0000, 1'b1, 32'hFFFF_0000},
            '{OP_READ,    41, 30, 32'h0000_0000, 1'b0, 32'h0000_0000}
        };
        phase_idle = '{0, 72, 0, 21};
        phase_k[0] = 15'd16384;
        phase_k[1] = 15'd0;
        phase_k[2] = 15'h7FFF;
        phase_k[3] = COEFF_W'($urandom_range(16384));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        // The clearing pass after reset keeps the block busy until the whole grid is cleared.
        settle();

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].op, dir_rows[i].col, dir_rows[i].row, dir_rows[i].amount,
                      dir_rows[i].pinned, dir_rows[i].pinned_value, 0);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_coupling(phase_k[ph]);
            focus_c = $urandom_range(COLS - 6, 5);
            focus_r = $urandom_range(ROWS - 6, 5);
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                if (ph == 1 && n == WORDS_PER_PHASE / 2)
                begin
                    settle();
                end
                random_word(phase_idle[ph], focus_c, focus_r);
            end
        end
        settle();

        $display("Accepted %0d words including %0d grid steps; %0d read-backs checked.",
                 n_words, n_steps, n_reads);
        $display("Coupling covered the reset value, zero, 16384, 32767 and %0d.", phase_k[3]);
        if (n_errors == 0 && readback_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/wgs_pkg.sv
hw/rtl/wgs_ram.sv
hw/rtl/wgs_ctrl.sv
hw/rtl/wgs_dpath.sv
hw/rtl/wave_grid_stencil_step_unit.sv
dv/tb.sv
